### rtl/core/egcd_pkg.sv
// ---------------------------------------------------------------------------
// egcd_pkg: shared constants and types for the extended GCD block
// Holds the default operand width and the divider status struct.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package egcd_pkg;

	localparam int unsigned EGCD_WIDTH = 64;
	localparam int unsigned PORT_W     = 64;

	// handshake between sequencer and shared divide/multiply unit
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} unit_ctl_t;

endpackage

### rtl/core/egcd_unit.sv
// ---------------------------------------------------------------------------
// egcd_unit: shared iterative arithmetic unit
// Restoring division of num by den (one quotient bit per cycle), then two
// shift-add multiplies of the quotient by the coefficients (one bit per
// cycle, both run side by side), giving next = last - q*cur.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module egcd_unit
	import egcd_pkg::*;
#(
	parameter int unsigned WIDTH = EGCD_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] num,
	input  logic [WIDTH-1:0] den,
	input  logic [WIDTH-1:0] cur_x,
	input  logic [WIDTH-1:0] last_x,
	input  logic [WIDTH-1:0] cur_y,
	input  logic [WIDTH-1:0] last_y,
	output logic             busy,
	output logic             done,
	output logic [WIDTH-1:0] rem,
	output logic [WIDTH-1:0] next_x,
	output logic [WIDTH-1:0] next_y
);

	localparam int unsigned CW = $clog2(WIDTH + 1);

	localparam logic [1:0] U_IDLE = 2'd0;
	localparam logic [1:0] U_DIV  = 2'd1;
	localparam logic [1:0] U_MUL  = 2'd2;
	localparam logic [1:0] U_DONE = 2'd3;

	logic [1:0]       state_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH-1:0] quo_q;   // dividend shifts out, quotient shifts in
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] den_q;
	logic [WIDTH-1:0] mx_q;    // multiplicand, shifted left
	logic [WIDTH-1:0] my_q;
	logic [WIDTH-1:0] ax_q;    // running last - q*cur
	logic [WIDTH-1:0] ay_q;

	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   shifted;

	// one restoring step
	always_comb begin
		shifted = {rem_q, quo_q[WIDTH-1]};
		trial   = shifted - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				U_IDLE: begin
					if (start) begin
						state_q <= U_DIV;
						cnt_q   <= CW'(WIDTH);
					end
				end
				U_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= U_MUL;
						cnt_q   <= CW'(WIDTH);
					end
				end
				U_MUL: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) state_q <= U_DONE;
				end
				U_DONE: state_q <= U_IDLE;
				default: state_q <= U_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == U_IDLE && start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
			mx_q  <= cur_x;
			my_q  <= cur_y;
			ax_q  <= last_x;
			ay_q  <= last_y;
		end else if (state_q == U_DIV) begin
			if (!trial[WIDTH]) begin
				rem_q <= trial[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], 1'b0};
			end
		end else if (state_q == U_MUL) begin
			// quotient bit from LSB, multiplicand doubles each step
			if (quo_q[0]) begin
				ax_q <= ax_q - mx_q;
				ay_q <= ay_q - my_q;
			end
			quo_q <= {1'b0, quo_q[WIDTH-1:1]};
			mx_q  <= {mx_q[WIDTH-2:0], 1'b0};
			my_q  <= {my_q[WIDTH-2:0], 1'b0};
		end
	end

	assign busy   = (state_q != U_IDLE);
	assign done   = (state_q == U_DONE);
	assign rem    = rem_q;
	assign next_x = ax_q;
	assign next_y = ay_q;

	a_done_from_mul: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == U_MUL)
		else $error("unit done without multiply phase");
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == U_MUL && den_q != '0) |-> rem_q < den_q)
		else $error("remainder not below divisor");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == U_IDLE && start) |=> state_q == U_DIV)
		else $error("unit failed to start");

endmodule

### rtl/core/egcd_seq.sv
// ---------------------------------------------------------------------------
// egcd_seq: round sequencer
// Holds the remainder pair and coefficient pairs, launches one unit pass per
// Euclid round and stops when the divisor reaches zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module egcd_seq
	import egcd_pkg::*;
#(
	parameter int unsigned WIDTH = EGCD_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic [WIDTH-1:0] a_in,
	input  logic [WIDTH-1:0] b_in,
	output logic             finish,
	output logic             idle,
	output logic [WIDTH-1:0] res_x,
	output logic [WIDTH-1:0] res_y
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CHECK = 2'd1;
	localparam logic [1:0] S_WAIT  = 2'd2;

	logic [1:0]       state_q;
	logic [WIDTH-1:0] ra_q, rb_q, cx_q, px_q, cy_q, py_q;
	unit_ctl_t        ctl;
	logic [WIDTH-1:0] rem, nx, ny;

	assign ctl.start = (state_q == S_CHECK) && (rb_q != '0);

	egcd_unit #(.WIDTH(WIDTH)) u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.start),
		.num    (ra_q),
		.den    (rb_q),
		.cur_x  (cx_q),
		.last_x (px_q),
		.cur_y  (cy_q),
		.last_y (py_q),
		.busy   (ctl.busy),
		.done   (ctl.done),
		.rem    (rem),
		.next_x (nx),
		.next_y (ny)
	);

	// round control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (load) state_q <= S_CHECK;
				S_CHECK: state_q <= (rb_q == '0) ? S_IDLE : S_WAIT;
				S_WAIT:  if (ctl.done) state_q <= S_CHECK;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && load) begin
			ra_q <= a_in;
			rb_q <= b_in;
			cx_q <= '0;
			px_q <= WIDTH'(1);
			cy_q <= WIDTH'(1);
			py_q <= '0;
		end else if (state_q == S_WAIT && ctl.done) begin
			ra_q <= rb_q;
			rb_q <= rem;
			px_q <= cx_q;
			cx_q <= nx;
			py_q <= cy_q;
			cy_q <= ny;
		end
	end

	assign finish = (state_q == S_CHECK) && (rb_q == '0);
	assign idle   = (state_q == S_IDLE);
	assign res_x  = px_q;
	assign res_y  = py_q;

	a_wait_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT) |-> ctl.busy)
		else $error("waiting while unit idle");
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> state_q == S_IDLE)
		else $error("finish did not return to idle");
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.done |-> state_q == S_WAIT)
		else $error("unit done outside wait");

endmodule

### rtl/core/extended_gcd_coefficients.sv
// ---------------------------------------------------------------------------
// extended_gcd_coefficients: Bezout coefficients by extended Euclid
// Top level: input/output channels around the round sequencer.
// ---------------------------------------------------------------------------
// Usage:
//  Input channel: in_valid/in_stall with operand_a, operand_b. A transfer
//  takes place when in_valid is high and in_stall low. Only the low WIDTH
//  bits of each operand are used.
//  Output channel: out_valid/out_stall with coef_x, coef_y, the WIDTH-bit
//  two's complement coefficients sign-extended to 64 bits.
//  One item at a time: in_stall is high from the input transfer until the
//  result has been taken. Each Euclid round runs one check step, WIDTH
//  divide steps and WIDTH multiply steps on the shared divide/multiply
//  unit, and one done step. The result is offered once a check finds the
//  divisor zero; at WIDTH 64 an item takes at most about 93 rounds.
//  b = 0 finishes at the first check with x = 1, y = 0.
//  Reset clears all control state; no clearing pass is needed.
//  If the receiver stalls, the result is held steady until taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module extended_gcd_coefficients
	import egcd_pkg::*;
#(
	parameter int unsigned WIDTH = EGCD_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [PORT_W-1:0]        operand_a,
	input  logic [PORT_W-1:0]        operand_b,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [PORT_W-1:0] coef_x,
	output logic signed [PORT_W-1:0] coef_y
);

	logic             busy_q;
	logic             out_valid_q;
	logic             load, finish, idle;
	logic [WIDTH-1:0] res_x, res_y;
	logic [PORT_W-1:0] x_q, y_q;

	assign in_stall = busy_q;
	assign load     = in_valid && !busy_q;

	egcd_seq #(.WIDTH(WIDTH)) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.a_in   (operand_a[WIDTH-1:0]),
		.b_in   (operand_b[WIDTH-1:0]),
		.finish (finish),
		.idle   (idle),
		.res_x  (res_x),
		.res_y  (res_y)
	);

	// busy from accept until output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) busy_q <= 1'b1;
			else if (out_valid_q && !out_stall) busy_q <= 1'b0;
			if (finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// result register, sign extended
	always_ff @(posedge clk) begin
		if (finish) begin
			x_q <= PORT_W'($signed(res_x));
			y_q <= PORT_W'($signed(res_y));
		end
	end

	assign out_valid = out_valid_q;
	assign coef_x    = x_q;
	assign coef_y    = y_q;

	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> busy_q)
		else $error("result without item");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> idle)
		else $error("accept while sequencer busy");
	a_finish_one: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> !out_valid_q)
		else $error("second result for one item");

endmodule

### sim/extended_gcd_coefficients_test.sv
// ---------------------------------------------------------------------------
// extended_gcd_coefficients_test: self-checking bench for the Bezout block
// Drives operand pairs through the valid/stall input channel, predicts the
// coefficients with an independent extended Euclid model and compares every
// result transfer in order. The source idles and the receiver stalls at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module extended_gcd_coefficients_test;
	import egcd_pkg::*;

	localparam int unsigned W         = EGCD_WIDTH;
	localparam int          N_RANDOM  = 140;
	localparam longint      MAX_CYCLES = 20000000;

	// in-order store of predicted coefficient pairs
	class bezout_board;
		logic [PORT_W-1:0] exp_x[$];
		logic [PORT_W-1:0] exp_y[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// sign-extend a W-bit value to the port width
		function logic [PORT_W-1:0] widen(logic [W-1:0] v);
			logic [PORT_W-1:0] r;
			r = {{(PORT_W){v[W-1]}}};
			r[W-1:0] = v;
			return r;
		endfunction

		// extended Euclid on the low W bits, coefficients wrap modulo 2^W
		function void note_operands(logic [PORT_W-1:0] a, logic [PORT_W-1:0] b);
			logic [W-1:0] ra, rb, q, rem, cx, px, cy, py, nx, ny;
			ra = a[W-1:0];
			rb = b[W-1:0];
			cx = 0; px = 1; cy = 1; py = 0;
			while (rb != 0) begin
				q   = ra / rb;
				rem = ra % rb;
				nx  = px - q * cx;
				ny  = py - q * cy;
				ra = rb; rb = rem;
				px = cx; cx = nx;
				py = cy; cy = ny;
			end
			exp_x.push_back(widen(px));
			exp_y.push_back(widen(py));
		endfunction

		function void check_coefs(logic [PORT_W-1:0] x, logic [PORT_W-1:0] y);
			logic [PORT_W-1:0] ex, ey;
			if (exp_x.size() == 0) begin
				$error("unexpected result transfer: coef_x=%h coef_y=%h", x, y);
				errors++;
				return;
			end
			ex = exp_x.pop_front();
			ey = exp_y.pop_front();
			if (x !== ex) begin
				$error("coef_x: expected %h, actual %h", ex, x);
				errors++;
			end
			if (y !== ey) begin
				$error("coef_y: expected %h, actual %h", ey, y);
				errors++;
			end
		endfunction

		function int pending();
			return exp_x.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [PORT_W-1:0] operand_a;
	logic [PORT_W-1:0] operand_b;
	logic              out_valid;
	logic              out_stall;
	logic signed [PORT_W-1:0] coef_x;
	logic signed [PORT_W-1:0] coef_y;

	bezout_board board;
	longint      cycles;
	bit          hold_long;
	bit          stim_done;

	extended_gcd_coefficients #(.WIDTH(W)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_stall(out_stall),
		.coef_x(coef_x), .coef_y(coef_y)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		board     = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		out_stall = 1'b1;
		operand_a = '0;
		operand_b = '0;
		hold_long = 1'b0;
		stim_done = 1'b0;
	end

	// cycle limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: check transfers, random stall per result
	initial begin : sink
		int gap;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 11);
			if ($urandom_range(0, 3) == 0) gap = 0;
			if (gap != 0 || hold_long) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				while (hold_long) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			board.check_coefs(coef_x, coef_y);
		end
	end

	// one input transfer, after a random gap unless no_gap is set
	task automatic send_pair(logic [PORT_W-1:0] a, logic [PORT_W-1:0] b, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_operands(a, b);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [PORT_W-1:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// operand drawn from several shapes: small, full, sparse
	function automatic logic [PORT_W-1:0] rand_operand();
		case ($urandom_range(0, 4))
			0: return PORT_W'($urandom_range(0, 20));
			1: return rand64() >> $urandom_range(0, 63);
			2: return ~(64'd0) - PORT_W'($urandom_range(0, 3));
			3: return 64'd1 << $urandom_range(0, 63);
			default: return rand64();
		endcase
	endfunction

	// long receiver hold, counted in its own process
	initial begin : long_hold
		@(posedge arst_n);
		repeat (30) @(posedge clk);
		hold_long = 1'b1;
		repeat (3000) @(posedge clk);
		hold_long = 1'b0;
	end

	// stimulus
	initial begin : stim
		@(posedge clk);
		@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero operands, extremes, Fibonacci worst case
		send_pair(64'd0, 64'd0, 1'b0);
		send_pair(64'd12345, 64'd0, 1'b0);
		send_pair(64'd0, 64'd77, 1'b0);
		send_pair(~64'd0, ~64'd0, 1'b1);
		send_pair(~64'd0, 64'd1, 1'b1);
		send_pair(64'd1, ~64'd0, 1'b0);
		send_pair(~64'd0, ~64'd0 - 64'd1, 1'b0);
		send_pair(64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 1'b0);
		send_pair(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
		send_pair(64'd240, 64'd46, 1'b0);
		send_pair(64'd46, 64'd240, 1'b0);
		send_pair(64'd12200160415121876738, 64'd7540113804746346429, 1'b0);
		send_pair(64'd3, 64'd7, 1'b1);
		send_pair(64'd1000000007, 64'd998244353, 1'b0);
		send_pair(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0);

		// pause until every result is back
		wait_drained();

		for (int i = 0; i < N_RANDOM; i++) begin
			send_pair(rand_operand(), ($urandom_range(0, 15) == 0) ? 64'd0 : rand_operand(),
				$urandom_range(0, 4) == 0);
			if (i == N_RANDOM / 2) wait_drained();
		end

		wait_drained();
		repeat (50) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
